// ===== sv/affine_matrix_decompose_top_macros.svh =====
// Assertion macros for the affine matrix decomposition block.
// Included by the top level; depends on nothing else.
`ifndef AFFINE_MATRIX_DECOMPOSE_TOP_MACROS_SVH
`define AFFINE_MATRIX_DECOMPOSE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define AFD_ASSERT_IMP(lbl, ck, rst_n, pre, post) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("affine decompose check failed");

// Next-cycle implication, disabled while reset is low.
`define AFD_ASSERT_NXT(lbl, ck, rst_n, pre, post) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("affine decompose check failed");

`endif

// ===== sv/afd_pkg.sv =====
// Shared constants, types and helpers of the affine matrix decomposition block.
// Used by the square root and divider pipelines and by the top level.
package afd_pkg;

	// Fraction bits of the normalized matrix and of the quaternion output.
	localparam int NF = 30;
	localparam int QUAT_FRAC_BITS = 30;
	localparam int QSH = NF - QUAT_FRAC_BITS;

	// Stage counts of the bit-serial pipelines.
	localparam int SQ_LAT = 32;
	localparam int DIV_LAT = 33;

	localparam logic signed [33:0] ONE_NF = 34'sd1 <<< NF;
	localparam logic signed [34:0] HALF_STEP = (35'sd1 <<< QSH) >>> 1;
	localparam logic signed [31:0] QUAT_ONE = 32'sd1 <<< QUAT_FRAC_BITS;
	localparam logic [31:0] SCALE_MAX = 32'h7fff_ffff;

	// Matrix stored as [column][component].
	typedef logic [2:0][2:0][31:0] mat_t;
	typedef logic [2:0][31:0] vec_t;

	// Cyclic successor of an axis index.
	function automatic logic [1:0] next_axis(input logic [1:0] a);
		logic [1:0] n;
		case (a)
			2'd0: n = 2'd1;
			2'd1: n = 2'd2;
			default: n = 2'd0;
		endcase
		return n;
	endfunction

	// Signed matrix element.
	function automatic logic signed [31:0] me(input mat_t m, input logic [1:0] a,
			input logic [1:0] b);
		return $signed(m[a][b]);
	endfunction

endpackage

// ===== sv/afd_isqrt.sv =====
// Pipelined floor square root of a 64-bit unsigned word, one result bit per stage.
// Depends on afd_pkg for the stage count.
module afd_isqrt
	import afd_pkg::*;
(
	input  logic        clk,
	input  logic        adv,
	input  logic [63:0] rad,
	output logic [31:0] root
);

	typedef struct packed {
		logic [65:0] rem;
		logic [31:0] res;
	} sq_stage_t;

	sq_stage_t st_s [SQ_LAT];

	// Each stage tries to set one root bit and keeps the residual n - r*r.
	for (genvar g = 0; g < SQ_LAT; g++) begin : g_bit
		localparam int B = SQ_LAT - 1 - g;
		sq_stage_t prev;
		sq_stage_t nxt;
		logic [65:0] trial;

		if (g == 0) begin : g_first
			assign prev = '{rem: {2'b00, rad}, res: '0};
		end else begin : g_rest
			assign prev = st_s[g-1];
		end

		always_comb begin
			trial = ({34'b0, prev.res} << (B + 1)) + (66'd1 << (2 * B));
			nxt = prev;
			if (prev.rem >= trial) begin
				nxt.rem = prev.rem - trial;
				nxt.res = prev.res | (32'd1 << B);
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				st_s[g] <= nxt;
			end
		end
	end

	assign root = st_s[SQ_LAT-1].res;

endmodule

// ===== sv/afd_div.sv =====
// Pipelined unsigned divider: (num << NF) / den, 32 quotient bits and an overflow flag.
// Depends on afd_pkg for the stage count and the fraction shift.
module afd_div
	import afd_pkg::*;
(
	input  logic        clk,
	input  logic        adv,
	input  logic [31:0] num,
	input  logic [32:0] den,
	output logic [31:0] quo,
	output logic        ovf
);

	typedef struct packed {
		logic [65:0] rem;
		logic [32:0] den;
		logic [31:0] quo;
		logic        ovf;
	} dv_stage_t;

	dv_stage_t st_s [DIV_LAT];
	dv_stage_t first;

	// Entry stage: scale the numerator and flag a quotient of 2^32 or more.
	always_comb begin
		first.rem = 66'(num) << NF;
		first.den = den;
		first.quo = '0;
		first.ovf = first.rem >= (66'(den) << 32);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[0] <= first;
		end
	end

	// Restoring stages, one quotient bit each, most significant first.
	for (genvar g = 1; g < DIV_LAT; g++) begin : g_bit
		localparam int B = DIV_LAT - 1 - g;
		dv_stage_t nxt;
		logic [65:0] trial;

		always_comb begin
			trial = 66'(st_s[g-1].den) << B;
			nxt = st_s[g-1];
			if (st_s[g-1].rem >= trial) begin
				nxt.rem = st_s[g-1].rem - trial;
				nxt.quo = st_s[g-1].quo | (32'd1 << B);
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				st_s[g] <= nxt;
			end
		end
	end

	assign quo = st_s[DIV_LAT-1].quo;
	assign ovf = st_s[DIV_LAT-1].ovf;

endmodule

// ===== sv/affine_matrix_decompose_top.sv =====
// Top level of the affine matrix decomposition pipeline.
// Depends on afd_pkg, afd_isqrt, afd_div and the assertion macro header.
//
//   channel   handshake              payload
//   input     in_valid / in_ready    c0_x .. c2_z, move_x .. move_z
//   output    out_valid / out_ready  out_move_*, scale_*, quat_*, degenerate
//
// One word enters per cycle while the output does not stall the pipeline.
// The pipeline runs through two 32-stage square root chains and two 33-stage
// divider chains, each producing one result bit per stage but for the divider entry stage.
// Reset clears only the valid bits; payload registers are not reset.
// A stall on the output freezes every stage at once, so nothing is lost or repeated.
`include "affine_matrix_decompose_top_macros.svh"
module affine_matrix_decompose_top
	import afd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] c0_x,
	input  logic signed [31:0] c0_y,
	input  logic signed [31:0] c0_z,
	input  logic signed [31:0] c1_x,
	input  logic signed [31:0] c1_y,
	input  logic signed [31:0] c1_z,
	input  logic signed [31:0] c2_x,
	input  logic signed [31:0] c2_y,
	input  logic signed [31:0] c2_z,
	input  logic signed [31:0] move_x,
	input  logic signed [31:0] move_y,
	input  logic signed [31:0] move_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_move_x,
	output logic signed [31:0] out_move_y,
	output logic signed [31:0] out_move_z,
	output logic signed [31:0] scale_x,
	output logic signed [31:0] scale_y,
	output logic signed [31:0] scale_z,
	output logic signed [31:0] quat_w,
	output logic signed [31:0] quat_x,
	output logic signed [31:0] quat_y,
	output logic signed [31:0] quat_z,
	output logic               degenerate
);

	localparam int VLD_LEN = 2 * SQ_LAT + 2 * DIV_LAT + 9;
	// Valid bit that travels with the outputs of the normalizing dividers.
	localparam int NORM_END = 2 + SQ_LAT + DIV_LAT - 1;

	typedef struct packed {
		mat_t c;
		vec_t mv;
	} front_t;

	typedef struct packed {
		logic [2:0][2:0] neg;
		vec_t            len;
		logic            degen;
		vec_t            mv;
	} dside_t;

	typedef struct packed {
		mat_t m;
		vec_t scl;
		logic degen;
		vec_t mv;
	} back_t;

	typedef struct packed {
		logic            pos;
		logic [1:0]      idx;
		logic [2:0][32:0] num;
		logic            degen;
		vec_t            scl;
		vec_t            mv;
	} bside_t;

	typedef struct packed {
		logic        pos;
		logic [1:0]  idx;
		logic [2:0]  neg;
		logic [31:0] root;
		logic        degen;
		vec_t        scl;
		vec_t        mv;
	} qside_t;

	typedef struct packed {
		vec_t            mv;
		vec_t            scl;
		logic [3:0][31:0] q;
		logic            degen;
	} res_t;

	// Quaternion rounding to the output fraction width.
	function automatic logic [31:0] qround(input logic signed [33:0] v);
		logic signed [34:0] t;
		t = 35'(v) + HALF_STEP;
		t = t >>> QSH;
		return t[31:0];
	endfunction

	logic               adv;
	logic [VLD_LEN-1:0] vld_s;

	// Whole-pipeline advance: move when the output register is free or being taken.
	assign adv = out_ready | ~out_valid;
	assign in_ready = adv;
	assign out_valid = vld_s[VLD_LEN-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[VLD_LEN-2:0], in_valid};
		end
	end

	// Stage 1: capture the word and square every basis component.
	mat_t                     in_mat;
	logic signed [63:0]       sq_c [3][3];
	front_t                   fr_s1;
	logic [2:0][2:0][62:0]    sq_s1;

	always_comb begin
		in_mat[0][0] = c0_x; in_mat[0][1] = c0_y; in_mat[0][2] = c0_z;
		in_mat[1][0] = c1_x; in_mat[1][1] = c1_y; in_mat[1][2] = c1_z;
		in_mat[2][0] = c2_x; in_mat[2][1] = c2_y; in_mat[2][2] = c2_z;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				sq_c[i][j] = $signed(in_mat[i][j]) * $signed(in_mat[i][j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fr_s1.c <= in_mat;
			fr_s1.mv <= {move_z, move_y, move_x};
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					sq_s1[i][j] <= sq_c[i][j][62:0];
				end
			end
		end
	end

	// Stage 2: sum of squares per column.
	front_t           fr_s2;
	logic [2:0][63:0] ss_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			fr_s2 <= fr_s1;
			for (int i = 0; i < 3; i++) begin
				ss_s2[i] <= {1'b0, sq_s1[i][0]} + {1'b0, sq_s1[i][1]} + {1'b0, sq_s1[i][2]};
			end
		end
	end

	// Column lengths.
	vec_t   len_w;
	front_t fr_sq_s [SQ_LAT];

	for (genvar i = 0; i < 3; i++) begin : g_len
		afd_isqrt u_len_sqrt (
			.clk  (clk),
			.adv  (adv),
			.rad  (ss_s2[i]),
			.root (len_w[i])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fr_sq_s[0] <= fr_s2;
			for (int g = 1; g < SQ_LAT; g++) begin
				fr_sq_s[g] <= fr_sq_s[g-1];
			end
		end
	end

	// Normalize each column by its length, sign and magnitude apart.
	front_t                fr_end;
	dside_t                ds_in;
	logic [2:0][2:0][31:0] cmag;
	logic [2:0][32:0]      den1;
	logic [2:0][2:0][31:0] q1_w;
	logic [2:0][2:0]       ovf1_w;
	dside_t                ds_dv_s [DIV_LAT];

	always_comb begin
		fr_end = fr_sq_s[SQ_LAT-1];
		for (int i = 0; i < 3; i++) begin
			den1[i] = (len_w[i] == '0) ? 33'd1 : {1'b0, len_w[i]};
			for (int j = 0; j < 3; j++) begin
				ds_in.neg[i][j] = fr_end.c[i][j][31];
				cmag[i][j] = fr_end.c[i][j][31] ? (32'd0 - fr_end.c[i][j]) : fr_end.c[i][j];
			end
		end
		ds_in.len = len_w;
		ds_in.degen = (len_w[0] == '0) || (len_w[1] == '0) || (len_w[2] == '0);
		ds_in.mv = fr_end.mv;
	end

	for (genvar i = 0; i < 3; i++) begin : g_ncol
		for (genvar j = 0; j < 3; j++) begin : g_ncomp
			afd_div u_norm_div (
				.clk (clk),
				.adv (adv),
				.num (cmag[i][j]),
				.den (den1[i]),
				.quo (q1_w[i][j]),
				.ovf (ovf1_w[i][j])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ds_dv_s[0] <= ds_in;
			for (int g = 1; g < DIV_LAT; g++) begin
				ds_dv_s[g] <= ds_dv_s[g-1];
			end
		end
	end

	// Stage 4: signed normalized matrix and saturated scale.
	dside_t ds_end;
	back_t  bk_s4;

	assign ds_end = ds_dv_s[DIV_LAT-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					bk_s4.m[i][j] <= ds_end.neg[i][j] ? (32'd0 - q1_w[i][j]) : q1_w[i][j];
				end
				bk_s4.scl[i] <= ds_end.len[i][31] ? SCALE_MAX : ds_end.len[i];
			end
			bk_s4.degen <= ds_end.degen;
			bk_s4.mv <= ds_end.mv;
		end
	end

	// Stage 5: cross product terms of columns 1 and 2.
	back_t              bk_s5;
	logic signed [63:0] pr_s5 [6];

	always_ff @(posedge clk) begin
		if (adv) begin
			bk_s5 <= bk_s4;
			pr_s5[0] <= me(bk_s4.m, 2'd1, 2'd1) * me(bk_s4.m, 2'd2, 2'd2);
			pr_s5[1] <= me(bk_s4.m, 2'd1, 2'd2) * me(bk_s4.m, 2'd2, 2'd1);
			pr_s5[2] <= me(bk_s4.m, 2'd1, 2'd2) * me(bk_s4.m, 2'd2, 2'd0);
			pr_s5[3] <= me(bk_s4.m, 2'd1, 2'd0) * me(bk_s4.m, 2'd2, 2'd2);
			pr_s5[4] <= me(bk_s4.m, 2'd1, 2'd0) * me(bk_s4.m, 2'd2, 2'd1);
			pr_s5[5] <= me(bk_s4.m, 2'd1, 2'd1) * me(bk_s4.m, 2'd2, 2'd0);
		end
	end

	// Stage 6: cross product, floored back to the matrix fraction width.
	back_t              bk_s6;
	logic signed [63:0] xd [3];
	logic signed [33:0] x_s6 [3];

	always_comb begin
		xd[0] = pr_s5[0] - pr_s5[1];
		xd[1] = pr_s5[2] - pr_s5[3];
		xd[2] = pr_s5[4] - pr_s5[5];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bk_s6 <= bk_s5;
			for (int k = 0; k < 3; k++) begin
				x_s6[k] <= xd[k][63:NF];
			end
		end
	end

	// Stage 7: dot of column 0 with the cross product.
	back_t              bk_s7;
	logic signed [65:0] dp_s7 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			bk_s7 <= bk_s6;
			for (int k = 0; k < 3; k++) begin
				dp_s7[k] <= me(bk_s6.m, 2'd0, 2'(k)) * x_s6[k];
			end
		end
	end

	// Stage 8: a negative triple product of a non-degenerate matrix flips scales and columns.
	back_t              bk_s8;
	logic signed [67:0] det;
	logic               flip;

	always_comb begin
		det = 68'(dp_s7[0]) + 68'(dp_s7[1]) + 68'(dp_s7[2]);
		flip = !bk_s7.degen && (det < 0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bk_s8.degen <= bk_s7.degen;
			bk_s8.mv <= bk_s7.mv;
			for (int i = 0; i < 3; i++) begin
				bk_s8.scl[i] <= flip ? (32'd0 - bk_s7.scl[i]) : bk_s7.scl[i];
				for (int j = 0; j < 3; j++) begin
					bk_s8.m[i][j] <= flip ? (32'd0 - bk_s7.m[i][j]) : bk_s7.m[i][j];
				end
			end
		end
	end

	// Stage 9: pick the trace or largest-diagonal branch and form the radicand.
	logic signed [31:0] d0, d1, d2, dmax;
	logic signed [33:0] tr;
	logic signed [34:0] arg, base;
	logic [1:0]         ix, jx, kx;
	bside_t             bs_in;
	bside_t             bs_s9;
	logic [63:0]        rad_s9;
	logic [63:0]        rad_c;

	always_comb begin
		d0 = me(bk_s8.m, 2'd0, 2'd0);
		d1 = me(bk_s8.m, 2'd1, 2'd1);
		d2 = me(bk_s8.m, 2'd2, 2'd2);
		tr = 34'(d0) + 34'(d1) + 34'(d2);
		ix = (d1 > d0) ? 2'd1 : 2'd0;
		dmax = (d1 > d0) ? d1 : d0;
		if (d2 > dmax) begin
			ix = 2'd2;
		end
		jx = next_axis(ix);
		kx = next_axis(jx);
		arg = 35'(me(bk_s8.m, ix, ix)) - 35'(me(bk_s8.m, jx, jx))
			- 35'(me(bk_s8.m, kx, kx)) + 35'(ONE_NF);
		bs_in.pos = tr > 0;
		if (bs_in.pos) begin
			base = 35'(tr) + 35'(ONE_NF);
			bs_in.num[0] = 33'(me(bk_s8.m, 2'd1, 2'd2)) - 33'(me(bk_s8.m, 2'd2, 2'd1));
			bs_in.num[1] = 33'(me(bk_s8.m, 2'd2, 2'd0)) - 33'(me(bk_s8.m, 2'd0, 2'd2));
			bs_in.num[2] = 33'(me(bk_s8.m, 2'd0, 2'd1)) - 33'(me(bk_s8.m, 2'd1, 2'd0));
		end else begin
			base = (arg < 0) ? 35'sd0 : arg;
			bs_in.num[0] = 33'(me(bk_s8.m, ix, jx)) + 33'(me(bk_s8.m, jx, ix));
			bs_in.num[1] = 33'(me(bk_s8.m, ix, kx)) + 33'(me(bk_s8.m, kx, ix));
			bs_in.num[2] = 33'(me(bk_s8.m, jx, kx)) - 33'(me(bk_s8.m, kx, jx));
		end
		rad_c = 64'($unsigned(base)) << NF;
		bs_in.idx = ix;
		bs_in.degen = bk_s8.degen;
		bs_in.scl = bk_s8.scl;
		bs_in.mv = bk_s8.mv;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bs_s9 <= bs_in;
			rad_s9 <= rad_c;
		end
	end

	// Quaternion root.
	logic [31:0] root_w;
	bside_t      bs_sq_s [SQ_LAT];

	afd_isqrt u_quat_sqrt (
		.clk  (clk),
		.adv  (adv),
		.rad  (rad_s9),
		.root (root_w)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			bs_sq_s[0] <= bs_s9;
			for (int g = 1; g < SQ_LAT; g++) begin
				bs_sq_s[g] <= bs_sq_s[g-1];
			end
		end
	end

	// Divide the three remaining terms by twice the root.
	bside_t           bs_end;
	qside_t           qs_in;
	logic [32:0]      den2;
	logic [2:0][32:0] nneg;
	logic [2:0][31:0] nabs;
	logic [2:0][31:0] q2_w;
	logic [2:0]       ovf2_w;
	qside_t           qs_dv_s [DIV_LAT];

	always_comb begin
		bs_end = bs_sq_s[SQ_LAT-1];
		den2 = (root_w == '0) ? 33'd1 : {root_w, 1'b0};
		for (int k = 0; k < 3; k++) begin
			nneg[k] = 33'd0 - bs_end.num[k];
			nabs[k] = bs_end.num[k][32] ? nneg[k][31:0] : bs_end.num[k][31:0];
			qs_in.neg[k] = bs_end.num[k][32];
		end
		qs_in.pos = bs_end.pos;
		qs_in.idx = bs_end.idx;
		qs_in.root = root_w;
		qs_in.degen = bs_end.degen;
		qs_in.scl = bs_end.scl;
		qs_in.mv = bs_end.mv;
	end

	for (genvar k = 0; k < 3; k++) begin : g_qdiv
		afd_div u_quat_div (
			.clk (clk),
			.adv (adv),
			.num (nabs[k]),
			.den (den2),
			.quo (q2_w[k]),
			.ovf (ovf2_w[k])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qs_dv_s[0] <= qs_in;
			for (int g = 1; g < DIV_LAT; g++) begin
				qs_dv_s[g] <= qs_dv_s[g-1];
			end
		end
	end

	// Output stage: saturate, place components by branch, round.
	qside_t             qs_end;
	logic [2:0][31:0]   qmag;
	logic signed [33:0] dv [3];
	logic signed [33:0] half;
	logic signed [33:0] vw;
	logic signed [33:0] vc [3];
	logic [1:0]         oj, ok;
	res_t               out_s;

	always_comb begin
		qs_end = qs_dv_s[DIV_LAT-1];
		for (int k = 0; k < 3; k++) begin
			qmag[k] = (ovf2_w[k] || (q2_w[k] > 32'(ONE_NF))) ? 32'(ONE_NF) : q2_w[k];
			dv[k] = qs_end.neg[k] ? -$signed({2'b00, qmag[k]}) : $signed({2'b00, qmag[k]});
		end
		half = $signed({3'b000, qs_end.root[31:1]});
		oj = next_axis(qs_end.idx);
		ok = next_axis(oj);
		vw = ONE_NF;
		for (int k = 0; k < 3; k++) begin
			vc[k] = '0;
		end
		if (!qs_end.degen) begin
			if (qs_end.pos) begin
				vw = half;
				for (int k = 0; k < 3; k++) begin
					vc[k] = dv[k];
				end
			end else begin
				vc[qs_end.idx] = half;
				if (qs_end.root == '0) begin
					vw = '0;
				end else begin
					vc[oj] = dv[0];
					vc[ok] = dv[1];
					vw = dv[2];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s.mv <= qs_end.mv;
			out_s.scl <= qs_end.scl;
			out_s.degen <= qs_end.degen;
			out_s.q[0] <= qround(vw);
			for (int k = 0; k < 3; k++) begin
				out_s.q[k+1] <= qround(vc[k]);
			end
		end
	end

	assign out_move_x = out_s.mv[0];
	assign out_move_y = out_s.mv[1];
	assign out_move_z = out_s.mv[2];
	assign scale_x = out_s.scl[0];
	assign scale_y = out_s.scl[1];
	assign scale_z = out_s.scl[2];
	assign quat_w = out_s.q[0];
	assign quat_x = out_s.q[1];
	assign quat_y = out_s.q[2];
	assign quat_z = out_s.q[3];
	assign degenerate = out_s.degen;

	// A degenerate matrix always yields the identity rotation.
	`AFD_ASSERT_IMP(a_degen_identity, clk, arst_n, out_valid && degenerate, quat_w == QUAT_ONE && quat_x == 0 && quat_y == 0 && quat_z == 0)
	// Quaternion components w and x stay within the unit range.
	`AFD_ASSERT_IMP(a_quat_range, clk, arst_n, out_valid, quat_w <= QUAT_ONE && quat_w >= -QUAT_ONE && quat_x <= QUAT_ONE && quat_x >= -QUAT_ONE)
	// A normalized entry of a non-degenerate matrix always fits the quotient width.
	`AFD_ASSERT_IMP(a_norm_fits, clk, arst_n, vld_s[NORM_END] && !ds_end.degen, ovf1_w == '0)
	// A stalled cycle leaves the occupancy of every stage as it was.
	`AFD_ASSERT_NXT(a_stall_hold, clk, arst_n, !adv, $stable(vld_s))

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the affine matrix decomposition block.
// Depends on afd_pkg and affine_matrix_decompose_top; a built-in predictor or a typed expectation checks every word.
`timescale 1ns / 1ps
module tb_top;
	import afd_pkg::*;

	localparam int RANDOM_WORDS = 1880;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 300;
	localparam longint ONE_Q = 64'sd1 <<< 30;

	typedef struct {
		logic signed [31:0] c [9];
		logic signed [31:0] mv [3];
	} matrix_word_t;

	typedef struct {
		logic signed [31:0] mv [3];
		logic signed [31:0] scl [3];
		logic signed [31:0] q [4];
		logic degen;
	} decomp_t;

	typedef struct {
		matrix_word_t m;
		bit known;
		decomp_t d;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [31:0] c0_x, c0_y, c0_z, c1_x, c1_y, c1_z, c2_x, c2_y, c2_z;
	logic signed [31:0] move_x, move_y, move_z;
	logic out_valid;
	logic out_ready;
	logic signed [31:0] out_move_x, out_move_y, out_move_z;
	logic signed [31:0] scale_x, scale_y, scale_z;
	logic signed [31:0] quat_w, quat_x, quat_y, quat_z;
	logic degenerate;

	decomp_t pending [$];
	stim_row_t rows [$];
	int errors = 0;
	int accepted = 0;
	int returned = 0;
	int degen_seen = 0;
	int flip_seen = 0;
	int idle_cycles = 0;
	bit feed_done = 0;

	affine_matrix_decompose_top u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.c0_x(c0_x), .c0_y(c0_y), .c0_z(c0_z), .c1_x(c1_x), .c1_y(c1_y), .c1_z(c1_z),
		.c2_x(c2_x), .c2_y(c2_y), .c2_z(c2_z),
		.move_x(move_x), .move_y(move_y), .move_z(move_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_move_x(out_move_x), .out_move_y(out_move_y), .out_move_z(out_move_z),
		.scale_x(scale_x), .scale_y(scale_y), .scale_z(scale_z),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.degenerate(degenerate)
	);

	// Floor integer square root, one result bit per pass.
	function automatic longint unsigned sqrt_floor(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Quotient scaled by 2^30, truncated toward zero.
	function automatic longint frac_div(input longint num, input longint den);
		return (num * ONE_Q) / den;
	endfunction

	// Saturate to [-1, 1] and round to nearest at the output fraction width.
	function automatic logic signed [31:0] quat_round(input longint v);
		if (v > ONE_Q)
			v = ONE_Q;
		if (v < -ONE_Q)
			v = -ONE_Q;
		if (QSH > 0)
			v = (v + (64'sd1 <<< (QSH - 1))) >>> QSH;
		return v[31:0];
	endfunction

	// Expected decomposition of one matrix word.
	function automatic decomp_t decompose(input matrix_word_t w);
		decomp_t d;
		longint c [3][3];
		longint nm [3][3];
		longint len [3];
		longint scl [3];
		longint q [3];
		longint qw, x0, x1, x2, det, tr, arg, root;
		longint unsigned ss;
		bit degen;
		int i, j, k;
		degen = 0;
		for (i = 0; i < 3; i++) begin
			ss = 0;
			for (j = 0; j < 3; j++) begin
				c[i][j] = w.c[i * 3 + j];
				ss += c[i][j] * c[i][j];
			end
			len[i] = sqrt_floor(ss);
			if (len[i] == 0)
				degen = 1;
			scl[i] = (len[i] > 64'sh7fff_ffff) ? 64'sh7fff_ffff : len[i];
		end
		q[0] = 0;
		q[1] = 0;
		q[2] = 0;
		qw = ONE_Q;
		if (!degen) begin
			for (i = 0; i < 3; i++)
				for (j = 0; j < 3; j++)
					nm[i][j] = frac_div(c[i][j], len[i]);
			x0 = (nm[1][1] * nm[2][2] - nm[1][2] * nm[2][1]) >>> 30;
			x1 = (nm[1][2] * nm[2][0] - nm[1][0] * nm[2][2]) >>> 30;
			x2 = (nm[1][0] * nm[2][1] - nm[1][1] * nm[2][0]) >>> 30;
			det = nm[0][0] * x0 + nm[0][1] * x1 + nm[0][2] * x2;
			// A mirrored basis flips every scale and every column.
			if (det < 0) begin
				for (i = 0; i < 3; i++) begin
					scl[i] = -scl[i];
					for (j = 0; j < 3; j++)
						nm[i][j] = -nm[i][j];
				end
			end
			tr = nm[0][0] + nm[1][1] + nm[2][2];
			if (tr > 0) begin
				root = sqrt_floor((tr + ONE_Q) << 30);
				qw = root >>> 1;
				q[0] = frac_div(nm[1][2] - nm[2][1], 2 * root);
				q[1] = frac_div(nm[2][0] - nm[0][2], 2 * root);
				q[2] = frac_div(nm[0][1] - nm[1][0], 2 * root);
			end else begin
				// Largest-diagonal branch.
				i = 0;
				if (nm[1][1] > nm[0][0])
					i = 1;
				if (nm[2][2] > nm[i][i])
					i = 2;
				j = (i + 1) % 3;
				k = (j + 1) % 3;
				arg = nm[i][i] - nm[j][j] - nm[k][k] + ONE_Q;
				if (arg < 0)
					arg = 0;
				root = sqrt_floor(arg << 30);
				q[i] = root >>> 1;
				if (root == 0) begin
					q[j] = 0;
					q[k] = 0;
					qw = 0;
				end else begin
					q[j] = frac_div(nm[i][j] + nm[j][i], 2 * root);
					q[k] = frac_div(nm[i][k] + nm[k][i], 2 * root);
					qw = frac_div(nm[j][k] - nm[k][j], 2 * root);
				end
			end
		end
		for (i = 0; i < 3; i++) begin
			d.mv[i] = w.mv[i];
			d.scl[i] = scl[i][31:0];
		end
		d.q[0] = quat_round(qw);
		d.q[1] = quat_round(q[0]);
		d.q[2] = quat_round(q[1]);
		d.q[3] = quat_round(q[2]);
		d.degen = degen;
		return d;
	endfunction

	// Append a stimulus row; the expectation is typed in when known is set.
	task automatic add_row(input logic signed [31:0] a0, a1, a2, b0, b1, b2, e0, e1, e2,
			input bit known, input logic signed [31:0] s, input logic signed [31:0] qw,
			input bit dg);
		stim_row_t r;
		r.m.c = '{a0, a1, a2, b0, b1, b2, e0, e1, e2};
		r.m.mv = '{$signed($urandom), $signed($urandom), $signed($urandom)};
		r.known = known;
		r.d.mv = r.m.mv;
		r.d.scl = '{s, s, s};
		r.d.q = '{qw, 32'sd0, 32'sd0, 32'sd0};
		r.d.degen = dg;
		rows.push_back(r);
	endtask

	// Random matrix: full-range noise, small values, signed axis permutations
	// with random scale, or a basis with a zero column.
	function automatic matrix_word_t random_matrix();
		matrix_word_t w;
		int kind, p, s, i;
		int perm [3];
		kind = $urandom_range(0, 9);
		for (i = 0; i < 9; i++)
			w.c[i] = 0;
		for (i = 0; i < 3; i++)
			w.mv[i] = $signed($urandom);
		if (kind <= 1) begin
			for (i = 0; i < 9; i++)
				w.c[i] = $signed($urandom);
		end else if (kind <= 4) begin
			for (i = 0; i < 9; i++)
				w.c[i] = $signed($urandom_range(0, 131071)) - 65536;
		end else if (kind <= 8) begin
			p = $urandom_range(0, 5);
			perm = '{p % 3, (p % 3 + 1 + p / 3) % 3, 0};
			perm[2] = 3 - perm[0] - perm[1];
			for (i = 0; i < 3; i++) begin
				s = $urandom_range(1, 1 << $urandom_range(0, 30));
				w.c[i * 3 + perm[i]] = $urandom_range(0, 1) ? -s : s;
				// Small perturbation off the exact axis.
				if ($urandom_range(0, 1))
					w.c[i * 3 + perm[(i + 1) % 3]] = $signed($urandom_range(0, 2047)) - 1024;
			end
		end else begin
			for (i = 0; i < 9; i++)
				w.c[i] = $signed($urandom_range(0, 4095)) - 2048;
			p = $urandom_range(0, 2);
			for (i = 0; i < 3; i++)
				w.c[p * 3 + i] = 0;
		end
		return w;
	endfunction

	// Clock.
	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Sender: reset, then the directed table, then random words.
	initial begin
		matrix_word_t w;
		int gap, n, burst;
		logic signed [31:0] one, mn, mx;
		one = 32'sd65536;
		mn = 32'sh8000_0000;
		mx = 32'sh7fff_ffff;
		arst_n = 0;
		in_valid = 0;
		{c0_x, c0_y, c0_z, c1_x, c1_y, c1_z, c2_x, c2_y, c2_z} = '0;
		{move_x, move_y, move_z} = '0;
		add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 32'sd1 <<< 30, 1);
		add_row(one, 0, 0, 0, one, 0, 0, 0, one, 1, one, 32'sd1 <<< 30, 0);
		add_row(-one, 0, 0, 0, -one, 0, 0, 0, -one, 1, -one, 32'sd1 <<< 30, 0);
		add_row(one, 0, 0, 0, 0, 0, 0, 0, one, 0, 0, 0, 0);
		add_row(mn, mn, mn, mn, mn, mn, mn, mn, mn, 0, 0, 0, 0);
		add_row(mx, mx, mx, mx, mx, mx, mx, mx, mx, 0, 0, 0, 0);
		add_row(mx, 0, 0, 0, mn, 0, 0, 0, mx, 0, 0, 0, 0);
		add_row(mn, 0, 0, 0, mn, 0, 0, 0, mn, 0, 0, 0, 0);
		add_row(1, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0);
		add_row(-one, 0, 0, 0, one, 0, 0, 0, one, 0, 0, 0, 0);
		add_row(one, 0, 0, 0, -one, 0, 0, 0, -one, 0, 0, 0, 0);
		add_row(-one, 0, 0, 0, one, 0, 0, 0, -one, 0, 0, 0, 0);
		add_row(-one, 0, 0, 0, -one, 0, 0, 0, one, 0, 0, 0, 0);
		add_row(0, one, 0, -one, 0, 0, 0, 0, one, 0, 0, 0, 0);
		add_row(0, one, 0, one, 0, 0, 0, 0, one, 0, 0, 0, 0);
		add_row(0, 0, one, one, 0, 0, 0, one, 0, 0, 0, 0, 0);
		add_row(one, one, 0, -one, one, 0, 0, 0, 2 * one, 0, 0, 0, 0);
		add_row(one, 0, 0, one, 0, 0, one, 0, 0, 0, 0, 0, 0);
		add_row(0, one, 0, one, 0, 0, one, 0, 0, 0, 0, 0, 0);
		add_row(-one, 0, 0, -one, 0, 0, -one, 0, 0, 0, 0, 0, 0);
		add_row(mx, mx, mx, one, 0, 0, 0, one, 0, 0, 0, 0, 0);
		add_row(3, 4, 0, -4, 3, 0, 0, 0, 5, 0, 0, 0, 0);
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		n = 0;
		burst = 0;
		while (n < rows.size() + RANDOM_WORDS) begin
			if (n < rows.size())
				w = rows[n].m;
			else
				w = random_matrix();
			// Every few hundred words, a stretch that runs without gaps.
			burst = ((n / 150) % 4 == 3);
			gap = burst ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1;
			{c0_x, c0_y, c0_z} <= {w.c[0], w.c[1], w.c[2]};
			{c1_x, c1_y, c1_z} <= {w.c[3], w.c[4], w.c[5]};
			{c2_x, c2_y, c2_z} <= {w.c[6], w.c[7], w.c[8]};
			{move_x, move_y, move_z} <= {w.mv[0], w.mv[1], w.mv[2]};
			do @(posedge clk); while (!in_ready);
			n++;
		end
		in_valid <= 0;
		feed_done = 1;
	end

	// Receiver: ready drops for a random wait before each word, except in no-wait stretches.
	initial begin
		int stall;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			stall = ((returned / 200) % 4 == 1) ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				out_ready <= 0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Prediction on input acceptance, comparison on output acceptance.
	always @(posedge clk) begin
		matrix_word_t w;
		decomp_t exp_d, got;
		bit bad;
		if (in_valid && in_ready && arst_n) begin
			w.c = '{c0_x, c0_y, c0_z, c1_x, c1_y, c1_z, c2_x, c2_y, c2_z};
			w.mv = '{move_x, move_y, move_z};
			exp_d = decompose(w);
			if (accepted < rows.size() && rows[accepted].known) begin
				exp_d = rows[accepted].d;
				exp_d.mv = w.mv;
			end
			pending.push_back(exp_d);
			accepted++;
		end
		if (out_valid && out_ready && arst_n) begin
			got.mv = '{out_move_x, out_move_y, out_move_z};
			got.scl = '{scale_x, scale_y, scale_z};
			got.q = '{quat_w, quat_x, quat_y, quat_z};
			got.degen = degenerate;
			returned++;
			if (degenerate)
				degen_seen++;
			if (scale_x < 0)
				flip_seen++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word at %0t", $realtime);
			end else begin
				exp_d = pending.pop_front();
				bad = (got.mv != exp_d.mv) || (got.scl != exp_d.scl) ||
					(got.q != exp_d.q) || (got.degen !== exp_d.degen);
				if (bad) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch on word %0d:", returned - 1);
						$display("  exp move %0d %0d %0d scale %0d %0d %0d", exp_d.mv[0],
							exp_d.mv[1], exp_d.mv[2], exp_d.scl[0], exp_d.scl[1],
							exp_d.scl[2]);
						$display("  got move %0d %0d %0d scale %0d %0d %0d", got.mv[0],
							got.mv[1], got.mv[2], got.scl[0], got.scl[1], got.scl[2]);
						$display("  exp quat %0d %0d %0d %0d degen %0b", exp_d.q[0],
							exp_d.q[1], exp_d.q[2], exp_d.q[3], exp_d.degen);
						$display("  got quat %0d %0d %0d %0d degen %0b", got.q[0],
							got.q[1], got.q[2], got.q[3], got.degen);
					end
				end
			end
		end
	end

	// Watchdog on cycles with no word moving on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no progress for %0d cycles", IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// End of run: drain, then a quiet stretch to catch stray words.
	initial begin
		wait (feed_done);
		while (pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		errors += pending.size();
		$display("checked %0d of %0d matrices, %0d degenerate, %0d mirrored", returned,
			accepted, degen_seen, flip_seen);
		$display("%0d mismatches", errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/afd_pkg.sv
sv/afd_isqrt.sv
sv/afd_div.sv
sv/affine_matrix_decompose_top.sv
tb/sv/tb_top.sv
